// ===== rtl/whd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package whd_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int DEF_MAX_WINDOW = 32;

    localparam logic [11:0] RST_IMAGE_WIDTH = 12'd400;
    localparam logic [5:0]  RST_WINDOW_ROWS = 6'd8;
    localparam logic [5:0]  RST_WINDOW_COLS = 6'd5;

    localparam int IN_W     = 24;
    localparam int OUT_W    = 88;
    localparam int POS_W    = 11;
    localparam int HASH_W   = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COLS = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HIST,
        ST_VERT,
        ST_RING,
        ST_PRIME,
        ST_HASH,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic hist_load;
        logic vert_step;
        logic ring_write;
        logic hash_issue;
        logic hash_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic win_valid;
        logic last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/window_hash_2d.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Streaming 2-D window hash over RGB raster pixels. Each pixel maps to one bit (1 when
// red, green and blue are all zero) and gives one output word: the bit, the hash
// modulo 2^64 of the window_rows x window_cols bit window ending at that pixel (row
// weights powers of 5, column weights powers of 7), the window's top-left corner and
// a valid flag in m_tuser; hash and corner read zero when no full window ends there.
// s_tuser restarts the frame at row 0, column 0; the row count saturates at the last
// row. A single 64-bit accumulator steps first through the column's bit history, one bit
// per cycle, then, when a full window ends at the pixel, through the recent column
// hashes of the row, one per cycle, read from a small ring memory. The next pixel is
// taken while a finished word waits on m_tready. The column history memory needs no
// clearing pass: the first row of a frame overwrites it. Configuration must be written
// only while no pixel is in progress; the block itself does not enforce it.
module window_hash_2d #(
    parameter int MAX_WIDTH  = whd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = whd_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW = whd_pkg::DEF_MAX_WINDOW
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [whd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [whd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [whd_pkg::IN_W-1:0]        s_tdata,   // red, green, blue
    input  wire logic                            s_tuser,   // frame_start
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // pixel_is_black, top_row, left_col, window_hash, zero pad
    output logic [whd_pkg::OUT_W-1:0]            m_tdata,
    output logic                                 m_tuser    // window_valid
);

    logic [11:0] image_width_reg;
    logic [5:0]  window_rows_reg;
    logic [5:0]  window_cols_reg;

    whd_pkg::cmd_t cmd;
    whd_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= whd_pkg::RST_IMAGE_WIDTH;
            window_rows_reg <= whd_pkg::RST_WINDOW_ROWS;
            window_cols_reg <= whd_pkg::RST_WINDOW_COLS;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                whd_pkg::REG_IMAGE_WIDTH: image_width_reg <= cfg_data[11:0];
                whd_pkg::REG_WINDOW_ROWS: window_rows_reg <= cfg_data[5:0];
                whd_pkg::REG_WINDOW_COLS: window_cols_reg <= cfg_data[5:0];
                default:
                begin
                end
            endcase
        end
    end

    whd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    whd_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .image_width (image_width_reg),
        .window_rows (window_rows_reg),
        .window_cols (window_cols_reg),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .sts         (sts),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/whd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module whd_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output whd_pkg::cmd_t      cmd,
    input  wire whd_pkg::sts_t sts
);

    whd_pkg::state_t state_reg;
    whd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= whd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            whd_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = whd_pkg::ST_HIST;
                end
            end
            whd_pkg::ST_HIST:
            begin
                cmd.hist_load = 1'b1;
                state_next    = whd_pkg::ST_VERT;
            end
            whd_pkg::ST_VERT:
            begin
                // one history bit per cycle, oldest first
                cmd.vert_step = 1'b1;
                if (sts.last)
                begin
                    state_next = whd_pkg::ST_RING;
                end
            end
            whd_pkg::ST_RING:
            begin
                cmd.ring_write = 1'b1;
                if (sts.win_valid)
                begin
                    state_next = whd_pkg::ST_PRIME;
                end
                else
                begin
                    state_next = whd_pkg::ST_OUTPUT;
                end
            end
            whd_pkg::ST_PRIME:
            begin
                cmd.hash_issue = 1'b1;
                state_next     = whd_pkg::ST_HASH;
            end
            whd_pkg::ST_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (sts.last)
                begin
                    state_next = whd_pkg::ST_OUTPUT;
                end
                else
                begin
                    cmd.hash_issue = 1'b1;
                end
            end
            whd_pkg::ST_OUTPUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = whd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = whd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/whd_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module whd_dp #(
    parameter int MAX_WIDTH  = whd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = whd_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW = whd_pkg::DEF_MAX_WINDOW
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [11:0]                image_width,
    input  wire logic [5:0]                 window_rows,
    input  wire logic [5:0]                 window_cols,
    input  wire logic [whd_pkg::IN_W-1:0]   s_tdata,
    input  wire logic                       s_tuser,
    input  wire whd_pkg::cmd_t              cmd,
    output whd_pkg::sts_t                   sts,
    input  wire logic                       m_tready,
    output logic                            m_tvalid,
    output logic [whd_pkg::OUT_W-1:0]       m_tdata,
    output logic                            m_tuser
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int W_W   = $clog2(MAX_WIDTH + 1);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int RI_W  = $clog2(MAX_WINDOW);
    localparam int RING  = 1 << RI_W;
    localparam int PW    = ROW_W + CNT_W + 12;
    localparam int CPW   = COL_W + CNT_W + 12;
    localparam int POS_W = whd_pkg::POS_W;
    localparam int HW    = whd_pkg::HASH_W;

    function automatic logic [ROW_W-1:0] row_step(input logic [ROW_W-1:0] r);
        // saturate on the last row
        if (32'(r) < MAX_HEIGHT - 1)
        begin
            return r + ROW_W'(1);
        end
        return r;
    endfunction

    logic [W_W-1:0]   w_eff;
    logic [CNT_W-1:0] m_eff;
    logic [CNT_W-1:0] n_eff;

    logic [ROW_W-1:0] row_pos_reg, row_pos_next;
    logic [COL_W-1:0] col_pos_reg, col_pos_next;
    logic [ROW_W-1:0] row_now;
    logic [COL_W-1:0] col_now;
    logic [W_W-1:0]   col_inc;
    logic             bit_now;
    logic             valid_now;
    logic [PW-1:0]    top_full;
    logic [CPW-1:0]   left_full;
    logic [CPW-1:0]   ptr_full;
    logic [CPW-1:0]   ring_idx_full;

    logic               bit_reg;
    logic               row_zero_reg;
    logic [COL_W-1:0]   cur_col_reg;
    logic               valid_reg;
    logic [POS_W-1:0]   top_reg;
    logic [POS_W-1:0]   left_reg;
    logic [MAX_WINDOW-1:0] hist_reg;
    logic [MAX_WINDOW-1:0] hist_rd_reg;
    logic [MAX_WINDOW-1:0] hist_new;
    logic [HW-1:0]      acc_reg;
    logic [HW-1:0]      ring_rd_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [RI_W-1:0]    ptr_reg;
    logic [RI_W-1:0]    bit_idx;
    logic               m_tvalid_reg;
    logic [whd_pkg::OUT_W-1:0] m_tdata_reg;
    logic               m_tuser_reg;

    logic [MAX_WINDOW-1:0] hist_mem [MAX_WIDTH];
    logic [HW-1:0]         ring_mem [RING];

    // register values outside their range act as the nearest legal value
    always_comb
    begin
        if (image_width == 12'd0)
        begin
            w_eff = W_W'(1);
        end
        else if (32'(image_width) > MAX_WIDTH)
        begin
            w_eff = W_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = W_W'(image_width);
        end

        if (window_rows == 6'd0)
        begin
            m_eff = CNT_W'(1);
        end
        else if (32'(window_rows) > MAX_WINDOW)
        begin
            m_eff = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            m_eff = CNT_W'(window_rows);
        end

        if (window_cols == 6'd0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (32'(window_cols) > MAX_WINDOW)
        begin
            n_eff = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            n_eff = CNT_W'(window_cols);
        end
    end

    // position of the incoming pixel and of the one after it
    always_comb
    begin
        if (s_tuser)
        begin
            row_now = '0;
            col_now = '0;
        end
        else if (W_W'(col_pos_reg) >= w_eff)
        begin
            row_now = row_step(row_pos_reg);
            col_now = '0;
        end
        else
        begin
            row_now = row_pos_reg;
            col_now = col_pos_reg;
        end

        col_inc = W_W'(col_now) + W_W'(1);
        if (col_inc >= w_eff)
        begin
            col_pos_next = '0;
            row_pos_next = row_step(row_now);
        end
        else
        begin
            col_pos_next = COL_W'(col_inc);
            row_pos_next = row_now;
        end
    end

    assign bit_now = (s_tdata[7:0] == 8'd0) && (s_tdata[15:8] == 8'd0)
                     && (s_tdata[23:16] == 8'd0);

    assign top_full  = PW'(row_now) + PW'(1) - PW'(m_eff);
    assign left_full = CPW'(col_now) + CPW'(1) - CPW'(n_eff);
    assign valid_now = (PW'(row_now) + PW'(1) >= PW'(m_eff))
                       && (CPW'(col_now) + CPW'(1) >= CPW'(n_eff));

    assign ring_idx_full = CPW'(cur_col_reg);
    assign ptr_full      = CPW'(cur_col_reg) + CPW'(1) - CPW'(n_eff);

    assign hist_new = row_zero_reg ? MAX_WINDOW'(bit_reg)
                                   : {hist_rd_reg[MAX_WINDOW-2:0], bit_reg};
    assign bit_idx  = RI_W'(cnt_reg - CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg  <= '0;
            col_pos_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                row_pos_reg <= row_pos_next;
                col_pos_reg <= col_pos_next;
            end
            if (cmd.out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            bit_reg      <= bit_now;
            row_zero_reg <= (row_now == '0);
            cur_col_reg  <= col_now;
            valid_reg    <= valid_now;
            top_reg      <= valid_now ? top_full[POS_W-1:0] : '0;
            left_reg     <= valid_now ? left_full[POS_W-1:0] : '0;
        end
        if (cmd.hist_load)
        begin
            hist_reg <= hist_new;
            acc_reg  <= '0;
            cnt_reg  <= m_eff;
        end
        if (cmd.vert_step)
        begin
            acc_reg <= (acc_reg << 2) + acc_reg + HW'(hist_reg[bit_idx]);
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        if (cmd.ring_write)
        begin
            acc_reg <= '0;
            cnt_reg <= n_eff;
            ptr_reg <= ptr_full[RI_W-1:0];
        end
        if (cmd.hash_issue)
        begin
            ptr_reg <= ptr_reg + RI_W'(1);
        end
        if (cmd.hash_step)
        begin
            acc_reg <= (acc_reg << 3) - acc_reg + ring_rd_reg;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        if (cmd.out_load)
        begin
            m_tdata_reg <= {1'b0, (valid_reg ? acc_reg : HW'(0)), left_reg, top_reg,
                            bit_reg};
            m_tuser_reg <= valid_reg;
        end
    end

    // per-column bit history, newest bit in bit 0
    always_ff @(posedge clk)
    begin
        if (cmd.hist_load)
        begin
            hist_mem[cur_col_reg] <= hist_new;
        end
        if (cmd.accept)
        begin
            hist_rd_reg <= hist_mem[col_now];
        end
    end

    // column hashes of the latest columns of the current row
    always_ff @(posedge clk)
    begin
        if (cmd.ring_write)
        begin
            ring_mem[ring_idx_full[RI_W-1:0]] <= acc_reg;
        end
        if (cmd.hash_issue)
        begin
            ring_rd_reg <= ring_mem[ptr_reg];
        end
    end

    assign sts.win_valid = valid_reg;
    assign sts.last      = (cnt_reg == CNT_W'(1));
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire
